// ===== rtl/gradient_noise_3d_assert.svh =====
// ----------------------------------------------------------------------------
// gradient_noise_3d_assert.svh
// Assertion macros shared by the gradient noise RTL.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define GN3_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gn3 assertion failed: same-cycle implication");

// condition holds in the cycle after the trigger
`define GN3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gn3 assertion failed: next-cycle implication");

// invariant
`define GN3_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("gn3 assertion failed: invariant");

`endif

// ===== rtl/gn3_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants and types of the gradient noise block.
// ----------------------------------------------------------------------------
package gn3_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int CELL_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam logic [CELL_W-1:0] CELL_MASK = 8'd255;

   localparam int OUT_W   = 18;
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   // gradient and blend values: up to +/-2^(F+1), plus headroom
   localparam int VAL_W  = FRAC_BITS + 4;
   localparam int FADE_W = FRAC_BITS + 1;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam int OUT_DEPTH = 16;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic                             is_eval;
      logic [CELL_W-1:0]                tbl_index;
      logic [CELL_W-1:0]                tbl_value;
      logic [2:0][CELL_W-1:0]           cube;
      logic [2:0][FRAC_BITS-1:0]        frac;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic                    valid;
      logic signed [OUT_W-1:0] value;
   } rsp_push_type;

endpackage

// ===== rtl/gn3_front.sv =====
// ----------------------------------------------------------------------------
// gn3_front
// Accepts request beats, splits coordinates into cell and fraction, queues.
// ----------------------------------------------------------------------------
module gn3_front import gn3_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_opcode,
   input  logic [7:0]        req_table_index,
   input  logic [7:0]        req_table_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output q_head_type        head,
   input  logic              head_pop
);

   item_type          new_item;
   item_type          q_mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]   cnt_ff, cnt_in;
   logic              push_beat, pop_beat;

   always_comb begin
      new_item.is_eval   = (req_opcode == OP_EVAL);
      new_item.tbl_index = req_table_index;
      new_item.tbl_value = req_table_value;
      new_item.cube[0]   = req_coord_x[FRAC_BITS +: CELL_W] & CELL_MASK;
      new_item.cube[1]   = req_coord_y[FRAC_BITS +: CELL_W] & CELL_MASK;
      new_item.cube[2]   = req_coord_z[FRAC_BITS +: CELL_W] & CELL_MASK;
      new_item.frac[0]   = req_coord_x[FRAC_BITS-1:0];
      new_item.frac[1]   = req_coord_y[FRAC_BITS-1:0];
      new_item.frac[2]   = req_coord_z[FRAC_BITS-1:0];
   end

   assign req_full   = (cnt_ff == Q_CW'(Q_DEPTH));
   assign push_beat  = req_push && !req_full;
   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];
   assign pop_beat   = head_pop && head.valid;

   assign wr_ptr_in = push_beat ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop_beat ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + Q_CW'(push_beat) - Q_CW'(pop_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_beat) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/gn3_back.sv =====
// ----------------------------------------------------------------------------
// gn3_back
// Hash, fade, gradient, trilinear blend stages; one item per cycle on credit.
// ----------------------------------------------------------------------------
`include "gradient_noise_3d_assert.svh"

module gn3_back import gn3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_head_type   head,
   output logic         head_pop,
   input  logic         rsp_pop_beat,
   output rsp_push_type rsp_push
);

   localparam int MSQ_W   = 2 * FRAC_BITS;
   localparam int LIN_W   = FRAC_BITS + 6;
   localparam int MLIN_W  = 2 * LIN_W;
   localparam int POLY_W  = FRAC_BITS + 4;
   localparam int MFADE_W = FRAC_BITS + POLY_W;
   localparam int DIFF_W  = VAL_W + 1;
   localparam int PROD_W  = FADE_W + 1 + DIFF_W;
   localparam int SAT_W   = ((VAL_W > OUT_W) ? VAL_W : OUT_W) + 1;
   localparam int NCOPY   = 7;

   localparam logic signed [LIN_W-1:0] K_SIX     = LIN_W'(6);
   localparam logic signed [LIN_W-1:0] K_FIFTEEN = LIN_W'(15 * ONE);
   localparam logic signed [LIN_W-1:0] K_TEN     = LIN_W'(10 * ONE);
   localparam logic signed [VAL_W-1:0] K_ONE     = VAL_W'(ONE);
   localparam logic signed [SAT_W-1:0] K_SAT_MAX = SAT_W'(OUT_MAX);
   localparam logic signed [SAT_W-1:0] K_SAT_MIN = SAT_W'(OUT_MIN);

   function automatic logic signed [VAL_W-1:0] grad(
      input logic [3:0]              h,
      input logic signed [VAL_W-1:0] x,
      input logic signed [VAL_W-1:0] y,
      input logic signed [VAL_W-1:0] z
   );
      logic signed [VAL_W-1:0] u, v;
      u = (h < 4'd8) ? x : y;
      if (h < 4'd4) begin
         v = y;
      end else if (h == 4'd12 || h == 4'd14) begin
         v = x;
      end else begin
         v = z;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic signed [PROD_W-1:0] lerp_prod(
      input logic [FADE_W-1:0]       s,
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(b) - DIFF_W'(a);
      return PROD_W'(signed'({1'b0, s})) * PROD_W'(d);
   endfunction

   function automatic logic signed [VAL_W-1:0] lerp_sum(
      input logic signed [VAL_W-1:0]  a,
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] sh;
      sh = p >>> FRAC_BITS;
      return a + signed'(sh[VAL_W-1:0]);
   endfunction

   // ---- issue and credit ----
   logic              issue;
   logic [OUT_CW-1:0] inflight_ff, inflight_in;

   assign issue    = head.valid &&
                     (!head.item.is_eval || (inflight_ff < OUT_CW'(OUT_DEPTH)));
   assign head_pop = issue;
   assign inflight_in = inflight_ff + OUT_CW'(issue && head.item.is_eval)
                        - OUT_CW'(rsp_pop_beat);

   // ---- pipeline control ----
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic s3_ev_ff, s3_ev_in, s4_ev_ff, s4_ev_in, s5_ev_ff, s5_ev_in;
   logic s6_ev_ff, s6_ev_in, s7_ev_ff, s7_ev_in, s8_ev_ff, s8_ev_in;
   logic s9_ev_ff, s9_ev_in;

   item_type s1_item_ff, s2_item_ff, s3_item_ff;

   assign s1_valid_in = issue;
   assign s2_valid_in = s1_valid_ff;
   assign s3_ev_in    = s2_valid_ff && s2_item_ff.is_eval;
   assign s4_ev_in    = s3_ev_ff;
   assign s5_ev_in    = s4_ev_ff;
   assign s6_ev_in    = s5_ev_ff;
   assign s7_ev_in    = s6_ev_ff;
   assign s8_ev_in    = s7_ev_ff;
   assign s9_ev_in    = s8_ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ev_ff    <= 1'b0;
         s4_ev_ff    <= 1'b0;
         s5_ev_ff    <= 1'b0;
         s6_ev_ff    <= 1'b0;
         s7_ev_ff    <= 1'b0;
         s8_ev_ff    <= 1'b0;
         s9_ev_ff    <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_ev_ff    <= s3_ev_in;
         s4_ev_ff    <= s4_ev_in;
         s5_ev_ff    <= s5_ev_in;
         s6_ev_ff    <= s6_ev_in;
         s7_ev_ff    <= s7_ev_in;
         s8_ev_ff    <= s8_ev_in;
         s9_ev_ff    <= s9_ev_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= head.item;
      s2_item_ff <= s1_item_ff;
      s3_item_ff <= s2_item_ff;
   end

   // ---- permutation table copies ----
   // copy 0 serves the x level, copies 1-2 the y level, copies 3-6 the z level.
   // A load writes each copy as it passes that copy's stage, keeping order.
   logic [CELL_W-1:0] perm_mem_ff [NCOPY][PERM_DEPTH];
   logic              wr_en   [NCOPY];
   logic [CELL_W-1:0] wr_addr [NCOPY];
   logic [CELL_W-1:0] wr_data [NCOPY];
   logic [CELL_W-1:0] rd_addr0 [NCOPY];
   logic [CELL_W-1:0] rd_addr1 [NCOPY];
   logic [CELL_W-1:0] rd0_ff  [NCOPY];
   logic [CELL_W-1:0] rd1_ff  [NCOPY];
   logic [CELL_W-1:0] hash_a, hash_b;
   logic [CELL_W-1:0] hash_z [4];

   always_comb begin
      hash_a = rd0_ff[0] + s1_item_ff.cube[1];
      hash_b = rd1_ff[0] + s1_item_ff.cube[1];
      hash_z[0] = rd0_ff[1] + s2_item_ff.cube[2];   // aa
      hash_z[1] = rd1_ff[1] + s2_item_ff.cube[2];   // ab
      hash_z[2] = rd0_ff[2] + s2_item_ff.cube[2];   // ba
      hash_z[3] = rd1_ff[2] + s2_item_ff.cube[2];   // bb

      wr_en[0]    = issue && !head.item.is_eval;
      wr_addr[0]  = head.item.tbl_index;
      wr_data[0]  = head.item.tbl_value;
      rd_addr0[0] = head.item.cube[0];
      rd_addr1[0] = head.item.cube[0] + 1'b1;

      rd_addr0[1] = hash_a;
      rd_addr1[1] = hash_a + 1'b1;
      rd_addr0[2] = hash_b;
      rd_addr1[2] = hash_b + 1'b1;
      for (int j = 1; j < 3; j++) begin
         wr_en[j]   = s1_valid_ff && !s1_item_ff.is_eval;
         wr_addr[j] = s1_item_ff.tbl_index;
         wr_data[j] = s1_item_ff.tbl_value;
      end

      for (int j = 3; j < NCOPY; j++) begin
         wr_en[j]    = s2_valid_ff && !s2_item_ff.is_eval;
         wr_addr[j]  = s2_item_ff.tbl_index;
         wr_data[j]  = s2_item_ff.tbl_value;
         rd_addr0[j] = hash_z[j-3];
         rd_addr1[j] = hash_z[j-3] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NCOPY; j++) begin
         if (wr_en[j]) begin
            perm_mem_ff[j][wr_addr[j]] <= wr_data[j];
         end
         rd0_ff[j] <= perm_mem_ff[j][rd_addr0[j]];
         rd1_ff[j] <= perm_mem_ff[j][rd_addr1[j]];
      end
   end

   // ---- fade: 6t^5 - 15t^4 + 10t^3 ----
   logic signed [LIN_W-1:0]  t_s     [3];
   logic signed [LIN_W-1:0]  lin     [3];
   logic [MSQ_W-1:0]         m_sq_in [3], m_sq_ff [3];
   logic signed [MLIN_W-1:0] m_lin_in [3], m_lin_ff [3];
   logic signed [MLIN_W-1:0] lin_sh  [3];
   logic signed [LIN_W-1:0]  poly_s  [3];
   logic [POLY_W-1:0]        poly_in [3], poly_ff [3];
   logic [MSQ_W-1:0]         m_cube_in [3], m_cube_ff [3];
   logic [MFADE_W-1:0]       m_fade_in [3], m_fade_ff [3];
   logic [FADE_W-1:0]        fade_in [3], fade_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         t_s[j]      = signed'(LIN_W'(head.item.frac[j]));
         lin[j]      = K_SIX * t_s[j] - K_FIFTEEN;
         m_sq_in[j]  = MSQ_W'(head.item.frac[j]) * MSQ_W'(head.item.frac[j]);
         m_lin_in[j] = MLIN_W'(t_s[j]) * MLIN_W'(lin[j]);

         lin_sh[j]    = m_lin_ff[j] >>> FRAC_BITS;
         poly_s[j]    = signed'(lin_sh[j][LIN_W-1:0]) + K_TEN;
         poly_in[j]   = poly_s[j][POLY_W-1:0];
         m_cube_in[j] = MSQ_W'(m_sq_ff[j][FRAC_BITS +: FRAC_BITS])
                        * MSQ_W'(s1_item_ff.frac[j]);

         m_fade_in[j] = MFADE_W'(m_cube_ff[j][FRAC_BITS +: FRAC_BITS])
                        * MFADE_W'(poly_ff[j]);

         fade_in[j]   = m_fade_ff[j][FRAC_BITS +: FADE_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         m_sq_ff[j]   <= m_sq_in[j];
         m_lin_ff[j]  <= m_lin_in[j];
         poly_ff[j]   <= poly_in[j];
         m_cube_ff[j] <= m_cube_in[j];
         m_fade_ff[j] <= m_fade_in[j];
         fade_ff[j]   <= fade_in[j];
      end
   end

   // ---- corner gradients ----
   logic signed [VAL_W-1:0] off0 [3], off1 [3];
   logic signed [VAL_W-1:0] g_in [8], g_ff [8];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         off0[j] = signed'(VAL_W'(s3_item_ff.frac[j]));
         off1[j] = off0[j] - K_ONE;
      end
      // pairs along x: (aa, ba), (ab, bb), then the same at z+1
      g_in[0] = grad(rd0_ff[3][3:0], off0[0], off0[1], off0[2]);
      g_in[1] = grad(rd0_ff[5][3:0], off1[0], off0[1], off0[2]);
      g_in[2] = grad(rd0_ff[4][3:0], off0[0], off1[1], off0[2]);
      g_in[3] = grad(rd0_ff[6][3:0], off1[0], off1[1], off0[2]);
      g_in[4] = grad(rd1_ff[3][3:0], off0[0], off0[1], off1[2]);
      g_in[5] = grad(rd1_ff[5][3:0], off1[0], off0[1], off1[2]);
      g_in[6] = grad(rd1_ff[4][3:0], off0[0], off1[1], off1[2]);
      g_in[7] = grad(rd1_ff[6][3:0], off1[0], off1[1], off1[2]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         g_ff[k] <= g_in[k];
      end
   end

   // ---- blend along x, y, z: multiply stage then add stage ----
   logic signed [VAL_W-1:0]  ua_ff [4];
   logic signed [PROD_W-1:0] up_ff [4];
   logic signed [VAL_W-1:0]  ul_ff [4];
   logic signed [VAL_W-1:0]  va_ff [2];
   logic signed [PROD_W-1:0] vp_ff [2];
   logic signed [VAL_W-1:0]  vl_ff [2];
   logic signed [VAL_W-1:0]  wa_ff;
   logic signed [PROD_W-1:0] wp_ff;
   logic [FADE_W-1:0]        v5_ff, w5_ff, v6_ff, w6_ff, w7_ff, w8_ff;
   logic signed [VAL_W-1:0]  r_val;
   logic signed [SAT_W-1:0]  r_wide;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         ua_ff[k] <= g_ff[2*k];
         up_ff[k] <= lerp_prod(fade_ff[0], g_ff[2*k], g_ff[2*k+1]);
         ul_ff[k] <= lerp_sum(ua_ff[k], up_ff[k]);
      end
      for (int k = 0; k < 2; k++) begin
         va_ff[k] <= ul_ff[2*k];
         vp_ff[k] <= lerp_prod(v6_ff, ul_ff[2*k], ul_ff[2*k+1]);
         vl_ff[k] <= lerp_sum(va_ff[k], vp_ff[k]);
      end
      wa_ff <= vl_ff[0];
      wp_ff <= lerp_prod(w8_ff, vl_ff[0], vl_ff[1]);
      v5_ff <= fade_ff[1];
      w5_ff <= fade_ff[2];
      v6_ff <= v5_ff;
      w6_ff <= w5_ff;
      w7_ff <= w6_ff;
      w8_ff <= w7_ff;
   end

   always_comb begin
      r_val  = lerp_sum(wa_ff, wp_ff);
      r_wide = SAT_W'(r_val);
      rsp_push.valid = s9_ev_ff;
      if (r_wide > K_SAT_MAX) begin
         rsp_push.value = OUT_W'(K_SAT_MAX);
      end else if (r_wide < K_SAT_MIN) begin
         rsp_push.value = OUT_W'(K_SAT_MIN);
      end else begin
         rsp_push.value = r_wide[OUT_W-1:0];
      end
   end

   `GN3_ASSERT_ALWAYS(a_inflight_bound, clock, reset, inflight_ff <= OUT_CW'(OUT_DEPTH))
   `GN3_ASSERT_IMP(a_result_counted, clock, reset, s9_ev_ff, inflight_ff != '0)
   `GN3_ASSERT_IMP(a_pop_has_head, clock, reset, head_pop, head.valid)

endmodule

// ===== rtl/gn3_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// gn3_rsp_fifo
// Result queue; sized so that every issued evaluation has a slot.
// ----------------------------------------------------------------------------
`include "gradient_noise_3d_assert.svh"

module gn3_rsp_fifo import gn3_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  rsp_push_type            rsp_push,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic signed [OUT_W-1:0] rsp_noise_value,
   output logic                    rsp_pop_beat
);

   logic signed [OUT_W-1:0] mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0]       cnt_ff, cnt_in;

   assign rsp_empty       = (cnt_ff == '0);
   assign rsp_pop_beat    = rsp_pop && !rsp_empty;
   assign rsp_noise_value = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = rsp_push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = rsp_pop_beat ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + OUT_CW'(rsp_push.valid) - OUT_CW'(rsp_pop_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.valid) begin
         mem_ff[wr_ptr_ff] <= rsp_push.value;
      end
   end

   `GN3_ASSERT_IMP(a_no_overflow, clock, reset, rsp_push.valid, cnt_ff < OUT_CW'(OUT_DEPTH))
   `GN3_ASSERT_NEXT(a_push_shows, clock, reset, rsp_push.valid && !rsp_pop_beat, !rsp_empty)
   `GN3_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= OUT_CW'(OUT_DEPTH))

endmodule

// ===== rtl/gradient_noise_3d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3D improved gradient noise on signed Q16.16 points, Q1.16 saturated result.
// ----------------------------------------------------------------------------
// Throughput is one beat per clock: load and evaluate beats alike enter the
// back end at one per cycle, an evaluate beat only while the result queue
// has a slot free for it, because the 256-entry permutation table is kept
// in seven copies (one for the x hash level, two for y, four for z), each
// with two read ports, so each hash level makes all its lookups in its own
// pipeline stage without waiting for a port. An evaluate beat, once accepted,
// waits at the head of the front queue, passes the nine back end register
// stages set by the hash lookups, the fade multiplier chain and the three
// blend levels, then is written into the result queue; a load beat gives
// no result. The permutation table holds no defined contents after reset:
// software loads all 256 entries with load beats before evaluating. Loads and
// evaluates stay in order, so a point sees exactly the loads pushed before it.
// ----------------------------------------------------------------------------
module gradient_noise_3d import gn3_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_opcode,
   input  logic [7:0]              req_table_index,
   input  logic [7:0]              req_table_value,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   input  logic signed [31:0]      req_coord_z,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [OUT_W-1:0] rsp_noise_value
);

   q_head_type   head;
   logic         head_pop;
   logic         rsp_pop_beat;
   rsp_push_type rsp_push;

   // front: take beats, split coordinates, buffer a few items
   gn3_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .head            (head),
      .head_pop        (head_pop)
   );

   // back: table writes, hashing and arithmetic; never stalls once issued,
   // issue is held back only when the result queue could run out of room
   gn3_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_pop_beat (rsp_pop_beat),
      .rsp_push     (rsp_push)
   );

   // results wait here until popped
   gn3_rsp_fifo u_rsp_fifo (
      .clock           (clock),
      .reset           (reset),
      .rsp_push        (rsp_push),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_noise_value (rsp_noise_value),
      .rsp_pop_beat    (rsp_pop_beat)
   );

endmodule

// ===== dv/gradient_noise_3d_tb.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d_tb
// Self-checking bench for the 3D gradient noise block.
// ----------------------------------------------------------------------------
// Loads a shuffled permutation table, then runs a short list of directed
// points before a long random mix of evaluate beats and table reloads.
// Every evaluate result is checked in order against a local fixed-point
// predictor or typed-in value. Both sides idle and stall at random. One long
// receiver hold-off fills the block, and one sender pause drains it.
// ----------------------------------------------------------------------------
module gradient_noise_3d_tb import gn3_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RANDOM_BEATS = 1376;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  DRAIN_CYCLES = 30;
   localparam int  HOLD_CYCLES  = 300;

   logic                    clock;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic                    req_opcode;
   logic [7:0]              req_table_index;
   logic [7:0]              req_table_value;
   logic signed [31:0]      req_coord_x;
   logic signed [31:0]      req_coord_y;
   logic signed [31:0]      req_coord_z;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic signed [OUT_W-1:0] rsp_noise_value;

   gradient_noise_3d dut (.*);

   // one row of the directed list
   typedef struct {
      logic              op;
      logic [7:0]        index;
      logic [7:0]        value;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      bit                known;     // expected value typed in below
      logic signed [17:0] noise;
   } point_row_type;

   // bench copy of the permutation table
   logic [7:0]              perm_copy [PERM_DEPTH];
   logic signed [OUT_W-1:0] noise_queue [$];

   int  error_count   = 0;
   int  checked_count = 0;
   int  load_count    = 0;
   int  eval_count    = 0;
   int  cycle_count   = 0;
   bit  quiet_phase   = 0;   // no idling on either side
   bit  hold_request  = 0;   // sender asks receiver for a long hold-off
   bit  stim_done     = 0;

   // -------------------------------------------------------------------------
   // predictor, all scaled by 2^FRAC_BITS; >>> on longint floors
   // -------------------------------------------------------------------------
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint fade(longint t);
      longint one, t3, poly;
      one  = longint'(1) << FRAC_BITS;
      t3   = qmul(qmul(t, t), t);
      poly = qmul(t, 6 * t - 15 * one) + 10 * one;
      return qmul(t3, poly);
   endfunction

   function automatic longint blend(longint s, longint a, longint b);
      return a + qmul(s, b - a);
   endfunction

   function automatic longint corner_dot(logic [7:0] hash, longint x, longint y,
                                         longint z);
      logic [3:0] h;
      longint     u, v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic int hash(int i);
      return int'(perm_copy[i & 255]);
   endfunction

   function automatic logic signed [OUT_W-1:0] noise_at(logic [31:0] px,
                                                        logic [31:0] py,
                                                        logic [31:0] pz);
      int     cx, cy, cz, a, b, aa, ab, ba, bb;
      longint x, y, z, x1, y1, z1, u, v, w, r, one;
      one = longint'(1) << FRAC_BITS;
      cx  = int'(px[FRAC_BITS+7:FRAC_BITS]);
      cy  = int'(py[FRAC_BITS+7:FRAC_BITS]);
      cz  = int'(pz[FRAC_BITS+7:FRAC_BITS]);
      x   = longint'(px[FRAC_BITS-1:0]);
      y   = longint'(py[FRAC_BITS-1:0]);
      z   = longint'(pz[FRAC_BITS-1:0]);
      x1  = x - one;
      y1  = y - one;
      z1  = z - one;
      u   = fade(x);
      v   = fade(y);
      w   = fade(z);
      a   = hash(cx) + cy;
      b   = hash(cx + 1) + cy;
      aa  = hash(a) + cz;
      ab  = hash(a + 1) + cz;
      ba  = hash(b) + cz;
      bb  = hash(b + 1) + cz;
      r = blend(w,
             blend(v,
                blend(u, corner_dot(hash(aa), x, y, z), corner_dot(hash(ba), x1, y, z)),
                blend(u, corner_dot(hash(ab), x, y1, z), corner_dot(hash(bb), x1, y1, z))),
             blend(v,
                blend(u, corner_dot(hash(aa + 1), x, y, z1),
                         corner_dot(hash(ba + 1), x1, y, z1)),
                blend(u, corner_dot(hash(ab + 1), x, y1, z1),
                         corner_dot(hash(bb + 1), x1, y1, z1))));
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[OUT_W-1:0];
   endfunction

   // -------------------------------------------------------------------------
   // clock, reset, watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results pending", $time,
               cycle_count, noise_queue.size());
      $display("Test completed with failures");
      $finish;
   end

   // -------------------------------------------------------------------------
   // sender
   // -------------------------------------------------------------------------
   // drive one beat and wait for the edge that takes it; the predictor runs
   // at that edge so table loads land in order with the points
   task automatic send_beat(logic op, logic [7:0] index, logic [7:0] value,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit known, logic signed [17:0] typed);
      logic signed [OUT_W-1:0] predicted;
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_table_index <= index;
      req_table_value <= value;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (op == OP_LOAD) begin
         perm_copy[index] = value;
         load_count++;
      end else begin
         predicted = noise_at(x, y, z);
         noise_queue.push_back(known ? typed : predicted);
         eval_count++;
      end
   endtask

   // idle the request side for a random stretch; mostly short, a few long
   task automatic sender_gap();
      int n;
      if (quiet_phase) return;
      n = $urandom_range(0, 99);
      if (n < 60) return;
      n = (n < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // random coordinate: full range, near-integer fractions, or a small range
   function automatic logic [31:0] random_coord();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 7))
         0:       c[15:0] = 16'h0000;
         1:       c[15:0] = 16'hFFFF;
         2:       c[31:20] = {12{c[19]}};
         default: ;
      endcase
      return c;
   endfunction

   point_row_type point_rows [] = '{
      // integer points: every offset is a corner, so the noise is zero
      '{OP_EVAL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
      '{OP_EVAL, 8'hFF, 8'hFF, 32'hFFFF_0000, 32'h0005_0000, 32'h00FF_0000, 1'b1, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, '0},
      '{OP_EVAL, 8'h5A, 8'hA5, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 1'b1, '0},
      // fraction extremes, negative coordinates, wrapped cube index
      '{OP_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'hFFFF_8000, 32'h0001_8000, 32'hFFFE_4000, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h0100_8000, 32'h0200_4000, 32'h0300_C000, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000, 1'b0, '0},
      '{OP_EVAL, 8'hFF, 8'hFF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0, 1'b0, '0},
      // reload entries, then revisit: coordinates of a load are ignored
      '{OP_LOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_LOAD, 8'hFF, 8'h00, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0, '0},
      '{OP_EVAL, 8'h00, 8'h00, 32'h00FF_C000, 32'h00FF_4000, 32'h00FF_2000, 1'b0, '0}
   };

   initial begin
      int order [PERM_DEPTH];
      int j, t;
      logic [31:0] px, py, pz;

      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_opcode      <= OP_LOAD;
      req_table_index <= '0;
      req_table_value <= '0;
      req_coord_x     <= '0;
      req_coord_y     <= '0;
      req_coord_z     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // whole table first, a shuffled permutation
      for (int i = 0; i < PERM_DEPTH; i++) order[i] = i;
      for (int i = PERM_DEPTH - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < PERM_DEPTH; i++) begin
         send_beat(OP_LOAD, i[7:0], order[i][7:0], $urandom, $urandom, $urandom,
                   1'b0, '0);
         sender_gap();
      end

      foreach (point_rows[i]) begin
         send_beat(point_rows[i].op, point_rows[i].index, point_rows[i].value,
                   point_rows[i].x, point_rows[i].y, point_rows[i].z,
                   point_rows[i].known, point_rows[i].noise);
         sender_gap();
      end

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         quiet_phase = (n >= 900 && n < 1050);
         if (n == 300) hold_request = 1;   // receiver stalls; block fills
         if (n == 700) begin
            // drain fully before going on
            req_push <= 1'b0;
            @(posedge clock);
            while (noise_queue.size() != 0) @(posedge clock);
         end
         px = random_coord();
         py = random_coord();
         pz = random_coord();
         if ($urandom_range(0, 9) == 0)
            send_beat(OP_LOAD, 8'($urandom), 8'($urandom), px, py, pz, 1'b0, '0);
         else
            send_beat(OP_EVAL, 8'($urandom), 8'($urandom), px, py, pz, 1'b0, '0);
         sender_gap();
      end
      req_push <= 1'b0;
      stim_done = 1;

      while (noise_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d table loads and %0d points sent, %0d results checked",
               load_count, eval_count, checked_count);
      $display("directed corners, extremes, reloads, then random mix with stalls");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // receiver: check every popped beat, then choose the next pop
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      int hold;
      logic signed [OUT_W-1:0] want;
      stall = 0;
      hold  = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (noise_queue.size() == 0) begin
               $display("%0t: result with none expected: expected none, actual %0d",
                        $time, rsp_noise_value);
               error_count++;
            end else begin
               want = noise_queue.pop_front();
               checked_count++;
               if (rsp_noise_value !== want) begin
                  $display("%0t: noise_value mismatch: expected %0d, actual %0d",
                           $time, want, rsp_noise_value);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (quiet_phase || stim_done) begin
            rsp_pop <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_pop <= 1'b1;
         end else begin
            stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
            rsp_pop <= 1'b0;
         end
      end
   end

endmodule
